// ===== rtl/assert_macros.svh =====
// Assertion macros used by the scan rate governor core (srmg_core).
// No dependencies; included inside module bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/srmg_pkg.sv =====
// Types, codes and reset values for the scan rate mode governor.
// No dependencies.
`default_nettype none
package srmg_pkg;

    localparam int RATE_W   = 16;
    localparam int IDLE_W   = 32;
    localparam int FORCE_W  = 16;
    localparam int MODE_W   = 3;
    localparam int CFG_AW   = 3;
    localparam int CFG_DW   = 32;
    localparam int S_DATA_W = 72;
    localparam int M_DATA_W = 24;

    localparam int FORCE_GROUPS_DEF = 3;

    // mode codes
    localparam logic [MODE_W-1:0] MODE_SWITCH = 3'd0;
    localparam logic [MODE_W-1:0] MODE_HIGH   = 3'd1;
    localparam logic [MODE_W-1:0] MODE_LOW    = 3'd2;
    localparam logic [MODE_W-1:0] MODE_DEEP   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_PWROFF = 3'd4;
    localparam logic [MODE_W-1:0] MODE_NONE   = 3'd5;

    // register indexes
    localparam logic [CFG_AW-1:0] REG_RATE_HIGH  = 3'd0;
    localparam logic [CFG_AW-1:0] REG_RATE_LOW   = 3'd1;
    localparam logic [CFG_AW-1:0] REG_RATE_DEEP  = 3'd2;
    localparam logic [CFG_AW-1:0] REG_RATE_PWOFF = 3'd3;
    localparam logic [CFG_AW-1:0] REG_IDLE_LIMIT = 3'd4;
    localparam logic [CFG_AW-1:0] REG_FORCE_THR  = 3'd5;

    // reset values
    localparam logic [RATE_W-1:0]         RATE_HIGH_RST  = 16'd8;
    localparam logic [RATE_W-1:0]         RATE_LOW_RST   = 16'd40;
    localparam logic [RATE_W-1:0]         RATE_DEEP_RST  = 16'd100;
    localparam logic [RATE_W-1:0]         RATE_PWOFF_RST = 16'd0;
    localparam logic [IDLE_W-1:0]         IDLE_LIMIT_RST = 32'd1000;
    localparam logic signed [FORCE_W-1:0] FORCE_THR_RST  = 16'sd100;

    typedef struct packed {
        logic [RATE_W-1:0]         rate_high;
        logic [RATE_W-1:0]         rate_low;
        logic [RATE_W-1:0]         rate_deep_sleep;
        logic [RATE_W-1:0]         rate_power_off;
        logic [IDLE_W-1:0]         idle_limit;
        logic signed [FORCE_W-1:0] force_threshold;
    } cfg_t;

    typedef struct packed {
        logic                      command;
        logic [MODE_W-1:0]         mode;
        logic                      activity;
        logic                      host_off;
        logic [RATE_W-1:0]         timer_reload;
        logic signed [FORCE_W-1:0] force_a;
        logic signed [FORCE_W-1:0] force_b;
        logic signed [FORCE_W-1:0] force_c;
    } item_t;

endpackage
`default_nettype wire

// ===== rtl/srmg_cfg.sv =====
// Configuration register file of the scan rate mode governor.
// Depends on srmg_pkg.
`default_nettype none
module srmg_cfg (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  wire                          cfg_wr_en,
    input  wire [srmg_pkg::CFG_AW-1:0]   cfg_addr,
    input  wire [srmg_pkg::CFG_DW-1:0]   cfg_wdata,
    output srmg_pkg::cfg_t               cfg
);
    import srmg_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.rate_high       <= RATE_HIGH_RST;
            cfg_reg.rate_low        <= RATE_LOW_RST;
            cfg_reg.rate_deep_sleep <= RATE_DEEP_RST;
            cfg_reg.rate_power_off  <= RATE_PWOFF_RST;
            cfg_reg.idle_limit      <= IDLE_LIMIT_RST;
            cfg_reg.force_threshold <= FORCE_THR_RST;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_RATE_HIGH:  cfg_reg.rate_high       <= cfg_wdata[RATE_W-1:0];
                REG_RATE_LOW:   cfg_reg.rate_low        <= cfg_wdata[RATE_W-1:0];
                REG_RATE_DEEP:  cfg_reg.rate_deep_sleep <= cfg_wdata[RATE_W-1:0];
                REG_RATE_PWOFF: cfg_reg.rate_power_off  <= cfg_wdata[RATE_W-1:0];
                REG_IDLE_LIMIT: cfg_reg.idle_limit      <= cfg_wdata[IDLE_W-1:0];
                REG_FORCE_THR:  cfg_reg.force_threshold <= cfg_wdata[FORCE_W-1:0];
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule
`default_nettype wire

// ===== rtl/srmg_in_stage.sv =====
// Input register of the scan rate mode governor: unpacks and holds one beat.
// Depends on srmg_pkg.
`default_nettype none
module srmg_in_stage (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  wire                          s_tvalid,
    output logic                         s_tready,
    input  wire [srmg_pkg::S_DATA_W-1:0] s_tdata,
    input  wire                          s_tuser,
    input  wire                          take,
    output logic                         item_valid,
    output srmg_pkg::item_t              item
);
    import srmg_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;
    item_t item_next;
    logic  load;

    assign s_tready = !valid_reg || take;
    assign load     = s_tvalid && s_tready;

    always_comb begin
        item_next.command      = s_tuser;
        item_next.mode         = s_tdata[2:0];
        item_next.activity     = s_tdata[3];
        item_next.host_off     = s_tdata[4];
        item_next.timer_reload = s_tdata[20:5];
        item_next.force_a      = s_tdata[36:21];
        item_next.force_b      = s_tdata[52:37];
        item_next.force_c      = s_tdata[68:53];
        valid_next             = load || (valid_reg && !take);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            item_reg <= item_next;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule
`default_nettype wire

// ===== rtl/srmg_core.sv =====
// Period and idle-time update with state and result registers.
// Depends on srmg_pkg and assert_macros.svh.
`default_nettype none
module srmg_core #(
    parameter int FORCE_GROUPS = srmg_pkg::FORCE_GROUPS_DEF
) (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  wire srmg_pkg::cfg_t          cfg,
    input  wire                          item_valid,
    input  wire srmg_pkg::item_t         item,
    output logic                         take,
    output logic                         m_valid,
    input  wire                          m_ready,
    output logic [srmg_pkg::RATE_W-1:0]  m_period,
    output logic                         m_updated
);
    import srmg_pkg::*;
    `include "assert_macros.svh"

    logic [RATE_W-1:0] period_reg, period_next;
    logic [MODE_W-1:0] prev_mode_reg, prev_mode_next;
    logic [IDLE_W-1:0] idle_reg, idle_next;
    logic              m_valid_reg, m_valid_next;
    logic [RATE_W-1:0] m_period_reg;
    logic              m_updated_reg;
    logic              updated;

    logic [RATE_W-1:0] p_mode;
    logic [RATE_W-1:0] p_drop;
    logic [IDLE_W:0]   idle_sum;
    logic              at_high;
    logic              hot;

    assign take = item_valid && (!m_valid_reg || m_ready);

    always_comb begin
        period_next    = period_reg;
        prev_mode_next = prev_mode_reg;
        idle_next      = idle_reg;
        updated        = 1'b0;
        p_mode         = period_reg;
        p_drop         = period_reg;
        idle_sum       = '0;
        at_high        = 1'b0;
        hot            = 1'b0;

        if (item.command) begin
            period_next = cfg.rate_high;
            idle_next   = '0;
        end else begin
            if (item.mode != prev_mode_reg) begin
                case (item.mode)
                    MODE_SWITCH, MODE_HIGH: p_mode = cfg.rate_high;
                    MODE_LOW:               p_mode = cfg.rate_low;
                    MODE_DEEP:              p_mode = cfg.rate_deep_sleep;
                    MODE_PWROFF:            p_mode = cfg.rate_power_off;
                    default:                p_mode = period_reg;
                endcase
                prev_mode_next = item.mode;
                updated        = 1'b1;
            end
            period_next = p_mode;

            if (item.mode == MODE_SWITCH) begin
                at_high  = (p_mode == cfg.rate_high) || (item.timer_reload == cfg.rate_high);
                idle_sum = {1'b0, idle_reg} + {{(IDLE_W+1-RATE_W){1'b0}}, p_mode};
                if (!item.activity && (idle_reg < cfg.idle_limit) && at_high) begin
                    idle_next = idle_sum[IDLE_W] ? '1 : idle_sum[IDLE_W-1:0];
                end else begin
                    idle_next = '0;
                end

                p_drop = p_mode;
                if ((idle_next >= cfg.idle_limit) && at_high) begin
                    p_drop = item.host_off ? cfg.rate_power_off : cfg.rate_low;
                end

                hot = item.force_a > cfg.force_threshold;
                if (FORCE_GROUPS > 1 && item.force_b > cfg.force_threshold) hot = 1'b1;
                if (FORCE_GROUPS > 2 && item.force_c > cfg.force_threshold) hot = 1'b1;

                period_next = p_drop;
                if ((p_drop != cfg.rate_high || item.timer_reload != cfg.rate_high) && hot) begin
                    period_next = cfg.rate_high;
                end
                updated = 1'b1;
            end
        end

        m_valid_next = take || (m_valid_reg && !m_ready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            period_reg    <= RATE_HIGH_RST;
            prev_mode_reg <= MODE_NONE;
            idle_reg      <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            if (take) begin
                period_reg    <= period_next;
                prev_mode_reg <= prev_mode_next;
                idle_reg      <= idle_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            m_period_reg  <= period_next;
            m_updated_reg <= updated;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_period  = m_period_reg;
    assign m_updated = m_updated_reg;

    `ASSERT_NEXT(a_cmd_clears_idle, aclk, aresetn, take && item.command,
        idle_reg == '0 && !m_updated_reg && m_period_reg == $past(cfg.rate_high),
        "high speed command did not reload period and clear idle time")
    `ASSERT_NEXT(a_switch_updates, aclk, aresetn,
        take && !item.command && item.mode == MODE_SWITCH,
        m_updated_reg && m_valid_reg, "switch mode tick not flagged as updated")
    `ASSERT_NEXT(a_activity_clears_idle, aclk, aresetn,
        take && !item.command && item.mode == MODE_SWITCH && item.activity,
        idle_reg == '0, "activity did not clear idle time")
    `ASSERT_SAME(a_result_matches_state, aclk, aresetn, m_valid_reg && !item_valid,
        m_period_reg == period_reg, "pending result differs from period state")
    `ASSERT_NEXT(a_stall_holds_state, aclk, aresetn, !take,
        $stable(period_reg) && $stable(idle_reg) && $stable(prev_mode_reg),
        "state moved without an item")

endmodule
`default_nettype wire

// ===== rtl/scan_rate_mode_governor.sv =====
// Top level of the scan rate mode governor: config registers, input stage, core.
// Depends on srmg_pkg, srmg_cfg, srmg_in_stage and srmg_core.
//
// Takes one tick or enter-high-speed beat per clock while m_tready is high, and
// returns one result beat for each through the input register, then the result
// register. Throughput is one beat per cycle while m_tready is high, set by the
// update of the period, mode and idle-time registers in the core. A full input
// register accepts a new beat in the same cycle its item moves on, so a stalled
// result only stops input once both registers hold data. Registers may be written
// only while the block holds no beat; writes never touch the period or idle state.
`default_nettype none
module scan_rate_mode_governor #(
    parameter int FORCE_GROUPS = srmg_pkg::FORCE_GROUPS_DEF
) (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  wire                          s_tvalid,
    output logic                         s_tready,
    // mode[2:0], activity[3], host_off[4], timer_reload[20:5],
    // force_a[36:21], force_b[52:37], force_c[68:53], zero pad
    input  wire [srmg_pkg::S_DATA_W-1:0] s_tdata,
    // command
    input  wire                          s_tuser,
    output logic                         m_tvalid,
    input  wire                          m_tready,
    // period[15:0], period_updated[16], zero pad
    output logic [srmg_pkg::M_DATA_W-1:0] m_tdata,
    input  wire                          cfg_wr_en,
    input  wire [srmg_pkg::CFG_AW-1:0]   cfg_addr,
    input  wire [srmg_pkg::CFG_DW-1:0]   cfg_wdata
);
    import srmg_pkg::*;

    cfg_t              cfg;
    item_t             item;
    logic              item_valid;
    logic              take;
    logic [RATE_W-1:0] period;
    logic              period_updated;

    srmg_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    srmg_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .take       (take),
        .item_valid (item_valid),
        .item       (item)
    );

    srmg_core #(
        .FORCE_GROUPS (FORCE_GROUPS)
    ) u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .item_valid (item_valid),
        .item       (item),
        .take       (take),
        .m_valid    (m_tvalid),
        .m_ready    (m_tready),
        .m_period   (period),
        .m_updated  (period_updated)
    );

    assign m_tdata = {{(M_DATA_W-RATE_W-1){1'b0}}, period_updated, period};

endmodule
`default_nettype wire
